// ===== sv/pip_pkg.sv =====
// Shared types and constants of the point-in-polygon parity unit.
`timescale 1ns / 1ps

package pip_pkg;

	// Default coordinate width and depth of the queue between front and back.
	localparam int PIP_COORD_BITS = 24;
	localparam int PIP_QUEUE_DEPTH = 4;

	typedef enum logic {
		OP_START  = 1'b0,
		OP_VERTEX = 1'b1
	} pip_op_t;

	typedef enum logic [1:0] {
		LOC_INSIDE   = 2'd0,
		LOC_OUTSIDE  = 2'd1,
		LOC_BOUNDARY = 2'd2
	} pip_loc_t;

	// Classification of one accepted item, computed by the front part.
	typedef struct packed {
		logic is_start;  // start of a query: clears parity and boundary
		logic has_edge;  // vertex that closes an edge with the previous one
		logic last;      // closing vertex: a result is due
		logic behind;    // point lies before the edge origin along x or y
		logic cross_up;  // y1 < py <= y2
		logic cross_dn;  // y2 < py <= y1
	} pip_flags_t;

endpackage

// ===== sv/pip_front.sv =====
// Front part: accepts items, keeps query point and previous vertex, classifies edges.
`timescale 1ns / 1ps

module pip_front
	import pip_pkg::*;
#(
	parameter int COORD_BITS = PIP_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic                         last,
	output pip_flags_t                   flags,
	output logic signed [COORD_BITS:0]   ax,
	output logic signed [COORD_BITS:0]   ay,
	output logic signed [COORD_BITS:0]   bx,
	output logic signed [COORD_BITS:0]   by
);

	localparam int DW = COORD_BITS + 1;

	logic signed [COORD_BITS-1:0] query_px_q;
	logic signed [COORD_BITS-1:0] query_py_q;
	logic signed [COORD_BITS-1:0] prev_vx_q;
	logic signed [COORD_BITS-1:0] prev_vy_q;
	logic                         have_prev_q;
	logic                         is_vertex;

	assign is_vertex = (pip_op_t'(op) == OP_VERTEX);

	// Edge vector from the previous vertex and vector to the query point.
	assign ax = DW'(coord_x) - DW'(prev_vx_q);
	assign ay = DW'(coord_y) - DW'(prev_vy_q);
	assign bx = DW'(query_px_q) - DW'(prev_vx_q);
	assign by = DW'(query_py_q) - DW'(prev_vy_q);

	always_comb begin
		flags.is_start = !is_vertex;
		flags.has_edge = is_vertex && have_prev_q;
		flags.last     = is_vertex && last;
		flags.behind   = ((ax < 0) && (bx > 0)) || ((ax > 0) && (bx < 0)) ||
		                 ((ay < 0) && (by > 0)) || ((ay > 0) && (by < 0));
		flags.cross_up = (prev_vy_q < query_py_q) && (query_py_q <= coord_y);
		flags.cross_dn = (coord_y < query_py_q) && (query_py_q <= prev_vy_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_px_q  <= '0;
			query_py_q  <= '0;
			prev_vx_q   <= '0;
			prev_vy_q   <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			if (is_vertex) begin
				prev_vx_q   <= coord_x;
				prev_vy_q   <= coord_y;
				have_prev_q <= !last;
			end else begin
				query_px_q  <= coord_x;
				query_py_q  <= coord_y;
				have_prev_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/pip_queue.sv =====
// Short first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps

module pip_queue
	import pip_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = PIP_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/pip_back.sv =====
// Back part: products, side and length tests, parity and boundary state, result register.
`timescale 1ns / 1ps

module pip_back
	import pip_pkg::*;
#(
	parameter int COORD_BITS = PIP_COORD_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  pip_flags_t                 flags,
	input  logic signed [COORD_BITS:0] ax,
	input  logic signed [COORD_BITS:0] ay,
	input  logic signed [COORD_BITS:0] bx,
	input  logic signed [COORD_BITS:0] by,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pip_loc_t                   location
);

	localparam int PW = 2 * (COORD_BITS + 1);

	logic                 advance;
	logic                 valid_s1;
	pip_flags_t           flags_s1;
	logic signed [PW-1:0] axby_s1;
	logic signed [PW-1:0] bxay_s1;
	logic signed [PW-1:0] axax_s1;
	logic signed [PW-1:0] ayay_s1;
	logic signed [PW-1:0] bxbx_s1;
	logic signed [PW-1:0] byby_s1;

	logic signed [PW:0]   cross_val;
	logic signed [PW:0]   len_edge;
	logic signed [PW:0]   len_point;
	logic                 beyond;
	logic                 parity_q;
	logic                 bnd_q;
	logic                 parity_nxt;
	logic                 bnd_nxt;
	logic                 out_valid_q;
	pip_loc_t             loc_q;

	// The whole back part moves unless a result is waiting and not taken.
	assign advance   = !out_valid_q || out_ready;
	assign q_pop     = q_valid && advance;
	assign out_valid = out_valid_q;
	assign location  = loc_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s1 <= flags;
			axby_s1  <= ax * by;
			bxay_s1  <= bx * ay;
			axax_s1  <= ax * ax;
			ayay_s1  <= ay * ay;
			bxbx_s1  <= bx * bx;
			byby_s1  <= by * by;
		end
	end

	assign cross_val = (PW+1)'(axby_s1) - (PW+1)'(bxay_s1);
	assign len_edge  = (PW+1)'(axax_s1) + (PW+1)'(ayay_s1);
	assign len_point = (PW+1)'(bxbx_s1) + (PW+1)'(byby_s1);
	assign beyond    = (len_edge < len_point);

	always_comb begin
		parity_nxt = parity_q;
		bnd_nxt    = bnd_q;
		if (flags_s1.is_start) begin
			parity_nxt = 1'b0;
			bnd_nxt    = 1'b0;
		end else if (flags_s1.has_edge) begin
			if (cross_val > 0) begin
				parity_nxt = parity_q ^ flags_s1.cross_up;
			end else if (cross_val < 0) begin
				parity_nxt = parity_q ^ flags_s1.cross_dn;
			end else if (!flags_s1.behind && !beyond) begin
				bnd_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			parity_q    <= 1'b0;
			bnd_q       <= 1'b0;
			out_valid_q <= 1'b0;
			loc_q       <= LOC_OUTSIDE;
		end else if (advance) begin
			valid_s1    <= q_valid;
			out_valid_q <= 1'b0;
			if (valid_s1) begin
				if (flags_s1.last) begin
					parity_q    <= 1'b0;
					bnd_q       <= 1'b0;
					out_valid_q <= 1'b1;
					if (bnd_nxt) begin
						loc_q <= LOC_BOUNDARY;
					end else if (parity_nxt) begin
						loc_q <= LOC_INSIDE;
					end else begin
						loc_q <= LOC_OUTSIDE;
					end
				end else begin
					parity_q <= parity_nxt;
					bnd_q    <= bnd_nxt;
				end
			end
		end
	end

endmodule

// ===== sv/point_in_polygon_parity_unit.sv =====
// Top level of the point-in-polygon parity unit.
//
//   Channel   Direction  Signals                       Payload
//   s_axis    in         tvalid tready tdata tuser     tdata: coord_x, coord_y; tuser: op;
//                        tlast                         tlast: last
//   m_axis    out        tvalid tready tdata           tdata: location
//
// One item is accepted per cycle while the queue has room; a closing vertex
// is written into the queue, its products are registered on the way out of
// the queue, then the state update loads the output register with the result.
// The six products of each edge get a register stage of their own.
// Reset clears all control state and the query point.
// A stalled output holds the back part; the queue lets the input side keep
// taking items until it is full.
`timescale 1ns / 1ps

module point_in_polygon_parity_unit
	import pip_pkg::*;
#(
	parameter int COORD_BITS = PIP_COORD_BITS,
	parameter int DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // coord_x, coord_y, zero fill
	input  logic              s_axis_tuser,  // op
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata   // location, zero fill
);

	localparam int DW = COORD_BITS + 1;
	localparam int QW = $bits(pip_flags_t) + 4 * DW;

	logic                         accept;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	pip_flags_t                   f_flags;
	logic signed [DW-1:0]         f_ax;
	logic signed [DW-1:0]         f_ay;
	logic signed [DW-1:0]         f_bx;
	logic signed [DW-1:0]         f_by;
	logic [QW-1:0]                q_in;
	logic [QW-1:0]                q_out;
	logic                         q_full;
	logic                         q_empty;
	logic                         q_pop;
	pip_flags_t                   b_flags;
	logic signed [DW-1:0]         b_ax;
	logic signed [DW-1:0]         b_ay;
	logic signed [DW-1:0]         b_bx;
	logic signed [DW-1:0]         b_by;
	pip_loc_t                     location;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && !q_full;
	assign coord_x       = $signed(s_axis_tdata[COORD_BITS-1:0]);
	assign coord_y       = $signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);

	pip_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (s_axis_tuser),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.last    (s_axis_tlast),
		.flags   (f_flags),
		.ax      (f_ax),
		.ay      (f_ay),
		.bx      (f_bx),
		.by      (f_by)
	);

	assign q_in = {f_flags, f_ax, f_ay, f_bx, f_by};

	pip_queue #(
		.WIDTH(QW),
		.DEPTH(PIP_QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign {b_flags, b_ax, b_ay, b_bx, b_by} = q_out;

	pip_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_pop     (q_pop),
		.flags     (b_flags),
		.ax        (b_ax),
		.ay        (b_ay),
		.bx        (b_bx),
		.by        (b_by),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.location  (location)
	);

	assign m_axis_tdata = {6'b0, location};

endmodule

// ===== sim/pip_checker.sv =====
// Checker for the point-in-polygon parity unit: predicts each verdict and compares it.
`timescale 1ns / 1ps

module pip_checker
	import pip_pkg::*;
#(
	parameter int COORD_BITS = PIP_COORD_BITS,
	parameter int DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // coord_x, coord_y, zero fill
	input  logic              s_axis_tuser,  // op
	input  logic              s_axis_tlast,
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [7:0]        m_axis_tdata,  // location, zero fill
	output int                fail_count,
	output int                verdicts_pending,
	output int                inside_count,
	output int                outside_count,
	output int                boundary_count
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * COORD_BITS + 3;
	localparam int VERDICT_SLOTS = 64;

	// Shadow copy of the block's state.
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] prev_x;
	logic signed [COORD_BITS-1:0] prev_y;
	logic                         prev_valid;
	logic                         crossing_odd;
	logic                         on_edge;

	// Ring of predicted verdicts, oldest at verdict_head.
	pip_loc_t expected_verdicts[VERDICT_SLOTS];
	int       verdict_head;
	int       verdict_tail;

	initial begin
		fail_count = 0;
		inside_count = 0;
		outside_count = 0;
		boundary_count = 0;
	end

	assign verdicts_pending = verdict_tail - verdict_head;

	task automatic report_mismatch(input string what);
		$display("%0t ns checker: %s", $time, what);
		fail_count++;
	endtask

	// Classifies the edge from the previous vertex to (x, y) against the query point.
	task automatic classify_edge(input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y);
		logic signed [DIFF_W-1:0] ax, ay, bx, by;
		logic signed [PROD_W-1:0] cross_prod, edge_len, point_len;
		ax = x - prev_x;
		ay = y - prev_y;
		bx = query_x - prev_x;
		by = query_y - prev_y;
		cross_prod = ax * by - bx * ay;
		if (cross_prod > 0) begin
			if (prev_y < query_y && query_y <= y)
				crossing_odd = !crossing_odd;
		end else if (cross_prod < 0) begin
			if (y < query_y && query_y <= prev_y)
				crossing_odd = !crossing_odd;
		end else begin
			edge_len = ax * ax + ay * ay;
			point_len = bx * bx + by * by;
			// Collinear: the point is on the edge unless it lies behind the
			// origin or past the far end.
			if (!((ax < 0 && bx > 0) || (ax > 0 && bx < 0) ||
					(ay < 0 && by > 0) || (ay > 0 && by < 0)) &&
					!(edge_len < point_len))
				on_edge = 1'b1;
		end
	endtask

	task automatic take_item(input pip_op_t op, input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y, input logic closing);
		pip_loc_t verdict;
		if (op == OP_START) begin
			query_x = x;
			query_y = y;
			prev_valid = 1'b0;
			crossing_odd = 1'b0;
			on_edge = 1'b0;
		end else begin
			if (prev_valid)
				classify_edge(x, y);
			prev_x = x;
			prev_y = y;
			prev_valid = 1'b1;
			if (closing) begin
				if (on_edge) begin
					verdict = LOC_BOUNDARY;
					boundary_count++;
				end else if (crossing_odd) begin
					verdict = LOC_INSIDE;
					inside_count++;
				end else begin
					verdict = LOC_OUTSIDE;
					outside_count++;
				end
				if (verdict_tail - verdict_head >= VERDICT_SLOTS) begin
					report_mismatch("too many verdicts outstanding");
				end else begin
					expected_verdicts[verdict_tail % VERDICT_SLOTS] = verdict;
					verdict_tail++;
				end
				prev_valid = 1'b0;
				crossing_odd = 1'b0;
				on_edge = 1'b0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x = '0;
			query_y = '0;
			prev_x = '0;
			prev_y = '0;
			prev_valid = 1'b0;
			crossing_odd = 1'b0;
			on_edge = 1'b0;
			verdict_head = 0;
			verdict_tail = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_tail == verdict_head) begin
					report_mismatch($sformatf("unexpected result transaction, location %0d",
						m_axis_tdata[1:0]));
				end else begin
					if (m_axis_tdata[1:0] !==
							expected_verdicts[verdict_head % VERDICT_SLOTS]) begin
						report_mismatch($sformatf("location %0d, expected %0d",
							m_axis_tdata[1:0],
							expected_verdicts[verdict_head % VERDICT_SLOTS]));
					end
					verdict_head++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_item(pip_op_t'(s_axis_tuser), s_axis_tdata[COORD_BITS-1:0],
					s_axis_tdata[2*COORD_BITS-1:COORD_BITS], s_axis_tlast);
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the point-in-polygon parity unit: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_top;
	import pip_pkg::*;

	localparam int CB = PIP_COORD_BITS;
	localparam int DATA_W = ((2 * CB + 7) / 8) * 8;
	localparam int TOTAL_ITEMS = 1650;
	localparam int CALM_ITEMS = 200;
	localparam int HOLD_AT_ITEM = 600;
	localparam int DRAIN_AT_ITEM = 1100;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_VERTS = 12;
	localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;
	logic              s_axis_tuser;
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;

	int fail_count;
	int verdicts_pending;
	int inside_count;
	int outside_count;
	int boundary_count;
	int items_sent;
	logic idling_on;
	logic long_hold_req;

	point_in_polygon_parity_unit #(
		.COORD_BITS(CB)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	pip_checker #(
		.COORD_BITS(CB)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.fail_count      (fail_count),
		.verdicts_pending(verdicts_pending),
		.inside_count    (inside_count),
		.outside_count   (outside_count),
		.boundary_count  (boundary_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: short random stalls, plus one long hold-off on request.
	initial begin
		logic hold_taken;
		hold_taken = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Ends the run when neither channel completes a transaction for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic logic signed [CB-1:0] rand_coord(input int mode);
		int kind;
		kind = (mode == 4) ? $urandom_range(0, 3) : mode;
		case (kind)
			0: rand_coord = CB'(int'($urandom_range(0, 16)) - 8);
			1: rand_coord = CB'($urandom());
			2: begin
				case ($urandom_range(0, 6))
					0: rand_coord = COORD_MIN;
					1: rand_coord = CB'(COORD_MIN + 1);
					2: rand_coord = '1;
					3: rand_coord = '0;
					4: rand_coord = CB'(1);
					5: rand_coord = CB'(COORD_MAX - 1);
					default: rand_coord = COORD_MAX;
				endcase
			end
			default: rand_coord = CB'((int'($urandom_range(0, 14)) - 7) * (1 << (CB - 4)));
		endcase
	endfunction

	// Offers one item and returns at the edge where its transaction completes.
	task automatic push_item(input pip_op_t op, input logic signed [CB-1:0] x,
			input logic signed [CB-1:0] y, input logic closing);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= DATA_W'({y, x});
		s_axis_tuser <= op;
		s_axis_tlast <= closing;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Withdraws the input and waits until every predicted verdict has come back.
	task automatic wait_for_verdicts();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (verdicts_pending != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		// Square around the origin before any start: the reset point is inside.
		push_item(OP_VERTEX, -4, -4, 1'b0);
		push_item(OP_VERTEX, 4, -4, 1'b0);
		push_item(OP_VERTEX, 4, 4, 1'b0);
		push_item(OP_VERTEX, -4, 4, 1'b0);
		push_item(OP_VERTEX, -4, -4, 1'b1);
		// A start with tlast set, then a lone closing vertex with no edge.
		push_item(OP_START, 1, 1, 1'b1);
		push_item(OP_VERTEX, 1, 1, 1'b1);
		// Point at the far corner of a full-range triangle: boundary stays latched.
		push_item(OP_START, COORD_MAX, COORD_MAX, 1'b0);
		push_item(OP_VERTEX, COORD_MIN, COORD_MIN, 1'b0);
		push_item(OP_VERTEX, COORD_MAX, COORD_MIN, 1'b0);
		push_item(OP_VERTEX, COORD_MAX, COORD_MAX, 1'b0);
		push_item(OP_VERTEX, COORD_MIN, COORD_MIN, 1'b1);
		// Degenerate edges, on the point and away from it, same query point.
		push_item(OP_START, 0, 0, 1'b0);
		push_item(OP_VERTEX, 0, 0, 1'b0);
		push_item(OP_VERTEX, 0, 0, 1'b1);
		push_item(OP_VERTEX, 5, 5, 1'b0);
		push_item(OP_VERTEX, 5, 5, 1'b1);
		// Full-range square around the origin.
		push_item(OP_VERTEX, COORD_MIN, COORD_MIN, 1'b0);
		push_item(OP_VERTEX, COORD_MAX, COORD_MIN, 1'b0);
		push_item(OP_VERTEX, COORD_MAX, COORD_MAX, 1'b0);
		push_item(OP_VERTEX, COORD_MIN, COORD_MAX, 1'b0);
		push_item(OP_VERTEX, COORD_MIN, COORD_MIN, 1'b1);
	endtask

	// One query: an optional start, then one to three polygons, mostly closed properly.
	task automatic run_random_query();
		int mode, npoly, nv, pick, idx;
		logic signed [CB-1:0] vx[MAX_VERTS];
		logic signed [CB-1:0] vy[MAX_VERTS];
		logic signed [CB-1:0] px, py;
		longint mid_x, mid_y;
		mode = $urandom_range(0, 4);
		npoly = $urandom_range(1, 3);
		for (int p = 0; p < npoly; p++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				nv = 1;
			else if (pick == 1)
				nv = 2;
			else if (pick < 4)
				nv = $urandom_range(8, MAX_VERTS);
			else
				nv = $urandom_range(3, 7);
			for (int i = 0; i < nv; i++) begin
				vx[i] = rand_coord(mode);
				vy[i] = rand_coord(mode);
			end
			if (p == 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					px = rand_coord(mode);
					py = rand_coord(mode);
				end else if (pick < 8) begin
					idx = $urandom_range(0, nv - 1);
					px = vx[idx];
					py = vy[idx];
				end else begin
					idx = (nv > 1) ? 1 : 0;
					mid_x = (longint'(vx[0]) + longint'(vx[idx])) >>> 1;
					mid_y = (longint'(vy[0]) + longint'(vy[idx])) >>> 1;
					px = mid_x[CB-1:0];
					py = mid_y[CB-1:0];
				end
				// Now and then the start is left out and the old point is reused.
				if ($urandom_range(0, 9) != 0)
					push_item(OP_START, px, py, 1'($urandom_range(0, 1)));
			end
			for (int i = 0; i < nv; i++)
				push_item(OP_VERTEX, vx[i], vy[i], 1'b0);
			pick = $urandom_range(0, 19);
			if (pick < 17)
				push_item(OP_VERTEX, vx[0], vy[0], 1'b1);
			else if (pick < 19)
				push_item(OP_VERTEX, rand_coord(mode), rand_coord(mode), 1'b1);
			// Otherwise the polygon stays open and the next vertices extend it.
		end
	endtask

	initial begin
		logic hold_done;
		logic drain_done;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		idling_on = 1'b1;
		long_hold_req = 1'b0;
		items_sent = 0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		while (items_sent < TOTAL_ITEMS) begin
			if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!drain_done && items_sent >= DRAIN_AT_ITEM) begin
				wait_for_verdicts();
				drain_done = 1'b1;
			end
			if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
				idling_on = 1'b0;
			run_random_query();
		end

		wait_for_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d items sent, %0d verdicts checked", items_sent,
			inside_count + outside_count + boundary_count);
		$display("tb: inside %0d, outside %0d, boundary %0d", inside_count, outside_count,
			boundary_count);
		if (fail_count == 0 && verdicts_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
